// ===== rtl/core/frcs_pkg.sv =====
`default_nettype none
package frcs_pkg;

    localparam int unsigned MAX_BANK_BYTES = 65536;
    localparam int unsigned POS_W = $clog2(MAX_BANK_BYTES + 1);
    localparam int unsigned LEN_W = 16;
    localparam int unsigned REV_W = 8;
    localparam int unsigned CRC_W = 32;
    localparam logic [CRC_W-1:0] CRC_POLY = 32'h04C1_1DB7;
    localparam int unsigned CFG_W = 17;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_TEXT = 3'd1,
        PH_REV  = 3'd2,
        PH_CRC0 = 3'd3,
        PH_CRC1 = 3'd4,
        PH_CRC2 = 3'd5,
        PH_CRC3 = 3'd6
    } scan_phase_t;

    typedef enum logic [1:0] {
        ST_GOOD     = 2'd0,
        ST_CRC_BAD  = 2'd1,
        ST_SIZE_BAD = 2'd2
    } check_status_t;

    typedef enum logic [1:0] {
        CH_BANK0 = 2'd0,
        CH_BANK1 = 2'd1,
        CH_NONE  = 2'd2
    } chosen_bank_t;

    typedef struct packed {
        logic             done;
        logic             bank;
        check_status_t    status;
        logic             good;
        logic [LEN_W-1:0] text_len;
        logic [REV_W-1:0] revision;
    } scan_result_t;

    // msb-first crc-32, one byte per call, no reflection
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                  input logic [7:0] data);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {data, 24'h0};
        for (int i = 0; i < 8; i++) begin
            c = c[CRC_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/frcs_scan.sv =====
`default_nettype none
module frcs_scan (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           step,
    input  wire logic [7:0]                     data_byte,
    input  wire logic                           scan_start,
    input  wire logic                           bank_id,
    input  wire logic [frcs_pkg::CFG_W-1:0]     size_cfg,
    output frcs_pkg::scan_result_t              result
);

    frcs_pkg::scan_phase_t              phase_reg, phase_next, phase_cur;
    logic [frcs_pkg::CRC_W-1:0]         crc_reg, crc_next, crc_base;
    logic [frcs_pkg::POS_W-1:0]         pos_reg, pos_next;
    logic [frcs_pkg::POS_W-1:0]         text_reg, text_next;
    logic [frcs_pkg::REV_W-1:0]         rev_reg, rev_next;
    logic [frcs_pkg::CFG_W-1:0]         limit;
    logic                               active;
    logic                               trailer_done;
    logic                               finish;

    always_comb begin
        phase_cur = scan_start ? frcs_pkg::PH_TEXT : phase_reg;
        crc_base  = scan_start ? '0 : crc_reg;
        pos_next  = (scan_start ? '0 : pos_reg) + frcs_pkg::POS_W'(1);
        text_next = scan_start ? '0 : text_reg;
        rev_next  = scan_start ? '0 : rev_reg;
        crc_next  = frcs_pkg::crc_byte(crc_base, data_byte);
        active    = (phase_cur != frcs_pkg::PH_IDLE);
        phase_next   = phase_cur;
        trailer_done = 1'b0;

        case (phase_cur)
            frcs_pkg::PH_TEXT: begin
                if (data_byte != 8'd0) begin
                    text_next = text_next + frcs_pkg::POS_W'(1);
                end else begin
                    phase_next = frcs_pkg::PH_REV;
                end
            end
            frcs_pkg::PH_REV: begin
                rev_next   = data_byte;
                phase_next = frcs_pkg::PH_CRC0;
            end
            frcs_pkg::PH_CRC0: phase_next = frcs_pkg::PH_CRC1;
            frcs_pkg::PH_CRC1: phase_next = frcs_pkg::PH_CRC2;
            frcs_pkg::PH_CRC2: phase_next = frcs_pkg::PH_CRC3;
            frcs_pkg::PH_CRC3: trailer_done = 1'b1;
            default: phase_next = frcs_pkg::PH_IDLE;
        endcase

        limit = (size_cfg > frcs_pkg::CFG_W'(frcs_pkg::MAX_BANK_BYTES))
              ? frcs_pkg::CFG_W'(frcs_pkg::MAX_BANK_BYTES) : size_cfg;
        finish = active && (trailer_done || (frcs_pkg::CFG_W'(pos_next) >= limit));
        if (finish) begin
            phase_next = frcs_pkg::PH_IDLE;
        end

        result.done     = finish;
        result.bank     = bank_id;
        result.status   = trailer_done
                        ? ((crc_next != '0) ? frcs_pkg::ST_CRC_BAD : frcs_pkg::ST_GOOD)
                        : frcs_pkg::ST_SIZE_BAD;
        // empty text is never good, even with a clean residue
        result.good     = trailer_done && (crc_next == '0) && (text_next != '0);
        result.text_len = text_next[frcs_pkg::LEN_W-1:0];
        result.revision = rev_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= frcs_pkg::PH_IDLE;
            crc_reg   <= '0;
            pos_reg   <= '0;
            text_reg  <= '0;
            rev_reg   <= '0;
        end else if (step && active) begin
            phase_reg <= phase_next;
            crc_reg   <= crc_next;
            pos_reg   <= pos_next;
            text_reg  <= text_next;
            rev_reg   <= rev_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/frcs_select.sv =====
`default_nettype none
module frcs_select (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       step,
    input  wire frcs_pkg::scan_result_t     result,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [47:0]                     m_tdata,
    output logic [0:0]                      m_tuser
);

    logic [1:0]                          good_reg, good_next;
    logic [frcs_pkg::LEN_W-1:0]          len_reg [2];
    logic [frcs_pkg::LEN_W-1:0]          len_next [2];
    logic [frcs_pkg::REV_W-1:0]          rev_reg [2];
    logic [frcs_pkg::REV_W-1:0]          rev_next [2];
    logic [frcs_pkg::REV_W-1:0]          rev_diff;
    frcs_pkg::chosen_bank_t              chosen;
    logic [frcs_pkg::LEN_W-1:0]          chosen_len;
    logic [frcs_pkg::LEN_W-1:0]          text_len;
    logic                                load;
    logic                                out_valid_reg;
    logic [47:0]                         out_data_reg;
    logic                                out_bank_reg;

    assign load = step && result.done;

    always_comb begin
        good_next = good_reg;
        len_next  = len_reg;
        rev_next  = rev_reg;
        text_len  = result.good ? result.text_len : '0;
        good_next[result.bank] = result.good;
        len_next[result.bank]  = text_len;
        rev_next[result.bank]  = result.revision;

        // signed revision distance, wraparound tolerant, ties to bank 0
        rev_diff = rev_next[0] - rev_next[1];
        if (good_next[0] && good_next[1]) begin
            chosen = rev_diff[frcs_pkg::REV_W-1] ? frcs_pkg::CH_BANK1 : frcs_pkg::CH_BANK0;
        end else if (good_next[1]) begin
            chosen = frcs_pkg::CH_BANK1;
        end else if (good_next[0]) begin
            chosen = frcs_pkg::CH_BANK0;
        end else begin
            chosen = frcs_pkg::CH_NONE;
        end

        case (chosen)
            frcs_pkg::CH_BANK0: chosen_len = len_next[0];
            frcs_pkg::CH_BANK1: chosen_len = len_next[1];
            default:            chosen_len = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            good_reg      <= '0;
            len_reg       <= '{default: '0};
            rev_reg       <= '{default: '0};
            out_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                good_reg      <= good_next;
                len_reg       <= len_next;
                rev_reg       <= rev_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_bank_reg <= result.bank;
            out_data_reg <= {4'd0, chosen_len, chosen, result.revision, text_len,
                             result.status};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_bank_reg;

endmodule
`default_nettype wire

// ===== rtl/core/flash_record_check_select_unit.sv =====
`default_nettype none
// a finishing byte's result is loaded into the output register as the byte leaves the input register
// throughput: one byte per cycle; a result waiting in the output register holds the input
// the crc, scan phase and counters advance as each byte leaves the input register
// reset (aresetn low, synchronous): scan idle, both banks not good, bank size 4096
module flash_record_check_select_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [frcs_pkg::CFG_W-1:0]     cfg_wr_data,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [7:0]                     s_tdata,   // data_byte
    input  wire logic [1:0]                     s_tuser,   // scan_start, bank_id
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // check_status[1:0], text_length[17:2], revision[25:18],
    // chosen_bank[27:26], chosen_length[43:28], zero pad
    output logic [47:0]                         m_tdata,
    output logic [0:0]                          m_tuser    // checked_bank
);

    logic [frcs_pkg::CFG_W-1:0]  size_cfg_reg;
    logic                        in_valid_reg;
    logic [7:0]                  in_byte_reg;
    logic                        in_start_reg;
    logic                        in_bank_reg;
    logic                        step;
    frcs_pkg::scan_result_t      result;

    assign step     = in_valid_reg && (!m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_cfg_reg <= frcs_pkg::CFG_W'(4096);
            in_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                size_cfg_reg <= cfg_wr_data;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser[0];
            in_bank_reg  <= s_tuser[1];
        end
    end

    frcs_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .data_byte  (in_byte_reg),
        .scan_start (in_start_reg),
        .bank_id    (in_bank_reg),
        .size_cfg   (size_cfg_reg),
        .result     (result)
    );

    frcs_select u_select (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .result   (result),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`default_nettype none
module testbench;

    localparam int unsigned QUIET_LIMIT = 3000;
    localparam int unsigned SETTLE_CYCLES = 8;

    typedef struct packed {
        logic                           bank;
        frcs_pkg::check_status_t        status;
        logic [frcs_pkg::LEN_W-1:0]     text_len;
        logic [frcs_pkg::REV_W-1:0]     rev;
        frcs_pkg::chosen_bank_t         chosen;
        logic [frcs_pkg::LEN_W-1:0]     chosen_len;
    } bank_report_t;

    typedef enum int {
        REC_GOOD,
        REC_CORRUPT,
        REC_CUT,
        REC_SKEW
    } record_kind_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [16:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // data_byte
    logic [1:0]  s_tuser;   // scan_start, bank_id
    logic        m_tvalid;
    logic        m_tready;
    // check_status, text_length, revision, chosen_bank, chosen_length, zero pad
    logic [47:0] m_tdata;
    logic [0:0]  m_tuser;   // checked_bank

    // predictor state
    frcs_pkg::scan_phase_t  scan_ph;
    logic [31:0]  scan_crc;
    int unsigned  scan_pos;
    int unsigned  text_seen;
    logic [7:0]   rev_seen;
    bit           bank_ok [2];
    int unsigned  bank_len [2];
    logic [7:0]   bank_rev [2];
    int unsigned  size_limit;

    bank_report_t expected_reports [$];
    logic [7:0]   record_bytes [$];
    int unsigned  mismatches;
    int unsigned  bytes_sent;
    int unsigned  quiet_cycles;
    bit           sender_gaps;
    bit           receiver_stalls;

    flash_record_check_select_unit DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] b);
        for (int i = 7; i >= 0; i--) begin
            c = {c[30:0], 1'b0} ^ ((c[31] ^ b[i]) ? frcs_pkg::CRC_POLY : 32'h0);
        end
        return c;
    endfunction

    function automatic logic [15:0] clip16(input int unsigned v);
        return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
    endfunction

    // returns 1 when this byte closes a scan, with the report it should produce
    function automatic bit predict_scan(input logic [7:0] b, input bit start, input bit bank,
                                        output bank_report_t rep);
        bit                       fin;
        bit                       ok;
        frcs_pkg::check_status_t  st;
        frcs_pkg::chosen_bank_t   ch;
        logic [7:0]               diff;
        fin = 1'b0;
        rep = '0;
        if (start) begin
            scan_ph = frcs_pkg::PH_TEXT;
            scan_crc = '0;
            scan_pos = 0;
            text_seen = 0;
            rev_seen = '0;
        end
        if (scan_ph == frcs_pkg::PH_IDLE) return 1'b0;
        scan_crc = crc_next(scan_crc, b);
        scan_pos++;
        case (scan_ph)
            frcs_pkg::PH_TEXT: begin
                if (b != 8'h00) text_seen++;
                else scan_ph = frcs_pkg::PH_REV;
            end
            frcs_pkg::PH_REV: begin
                rev_seen = b;
                scan_ph = frcs_pkg::PH_CRC0;
            end
            frcs_pkg::PH_CRC3: fin = 1'b1;
            default: scan_ph = frcs_pkg::scan_phase_t'(scan_ph + 3'd1);
        endcase
        if (fin) st = (scan_crc != '0) ? frcs_pkg::ST_CRC_BAD : frcs_pkg::ST_GOOD;
        else if (scan_pos >= size_limit) st = frcs_pkg::ST_SIZE_BAD;
        else return 1'b0;
        scan_ph = frcs_pkg::PH_IDLE;
        ok = (st == frcs_pkg::ST_GOOD) && (text_seen != 0);
        bank_ok[bank] = ok;
        bank_len[bank] = ok ? text_seen : 0;
        bank_rev[bank] = rev_seen;
        if (bank_ok[0] && bank_ok[1]) begin
            // signed 8-bit revision difference, ties keep bank 0
            diff = bank_rev[0] - bank_rev[1];
            ch = diff[7] ? frcs_pkg::CH_BANK1 : frcs_pkg::CH_BANK0;
        end else if (bank_ok[1]) begin
            ch = frcs_pkg::CH_BANK1;
        end else if (bank_ok[0]) begin
            ch = frcs_pkg::CH_BANK0;
        end else begin
            ch = frcs_pkg::CH_NONE;
        end
        rep.bank = bank;
        rep.status = st;
        rep.text_len = clip16(bank_len[bank]);
        rep.rev = rev_seen;
        rep.chosen = ch;
        rep.chosen_len = (ch == frcs_pkg::CH_NONE) ? 16'h0 : clip16(bank_len[ch[0]]);
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < 200)
            $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic send_byte(input logic [7:0] b, input bit start, input bit bank);
        bank_report_t rep;
        if (sender_gaps && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= {bank, start};
        do @(posedge aclk); while (!s_tready);
        if (predict_scan(b, start, bank, rep)) expected_reports.push_back(rep);
        bytes_sent++;
    endtask

    task automatic send_record(input bit bank, input int unsigned n, input logic [7:0] rev,
                               input record_kind_t kind);
        logic [31:0] c;
        int unsigned last;
        int unsigned i;
        bit          b;
        record_bytes.delete();
        c = '0;
        for (i = 0; i < n; i++) record_bytes.push_back(8'($urandom_range(1, 255)));
        record_bytes.push_back(8'h00);
        record_bytes.push_back(rev);
        foreach (record_bytes[j]) c = crc_next(c, record_bytes[j]);
        // crc appended msb first leaves a zero residue
        for (i = 0; i < 4; i++) record_bytes.push_back(c[31 - 8 * i -: 8]);
        last = record_bytes.size();
        if (kind == REC_CORRUPT) begin
            i = $urandom_range(0, last - 1);
            record_bytes[i] = record_bytes[i] ^ 8'($urandom_range(1, 255));
        end
        if (kind == REC_CUT) last = $urandom_range(1, last - 1);
        b = bank;
        for (i = 0; i < last; i++) begin
            if (kind == REC_SKEW && $urandom_range(0, 7) == 0) b = ~b;
            send_byte(record_bytes[i], i == 0, b);
        end
    endtask

    // waits until every pending result is out and the pipeline has emptied
    task automatic wait_idle;
        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_size(input logic [16:0] v);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        size_limit = (32'(v) > frcs_pkg::MAX_BANK_BYTES) ? frcs_pkg::MAX_BANK_BYTES : 32'(v);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_traffic(input int unsigned quota);
        int unsigned stop_at;
        int unsigned cap;
        int unsigned pick;
        int unsigned i;
        int unsigned cnt;
        bit          bank;
        logic [7:0]  rev;
        stop_at = bytes_sent + quota;
        cap = (size_limit < 6) ? 3 : ((size_limit > 54) ? 48 : size_limit - 4);
        while (bytes_sent < stop_at) begin
            bank = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
                0: rev = bank_rev[~bank];
                1: rev = bank_rev[~bank] + ($urandom_range(0, 1) ? 8'd127 : 8'd128);
                default: rev = 8'($urandom_range(0, 255));
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 66) begin
                send_record(bank, $urandom_range(0, cap), rev, REC_GOOD);
                // stray bytes past the trailer
                if ($urandom_range(0, 5) == 0) begin
                    cnt = $urandom_range(1, 3);
                    for (i = 0; i < cnt; i++)
                        send_byte(8'($urandom_range(0, 255)), 1'b0,
                                  1'($urandom_range(0, 1)));
                end
            end else if (pick < 76) begin
                send_record(bank, $urandom_range(0, cap), rev, REC_CORRUPT);
            end else if (pick < 84) begin
                send_record(bank, $urandom_range(0, cap), rev, REC_CUT);
            end else if (pick < 90) begin
                send_record(bank, $urandom_range(0, cap), rev, REC_SKEW);
            end else begin
                cnt = $urandom_range(1, 12);
                for (i = 0; i < cnt; i++)
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                              1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic test_directed_cases;
        send_byte(8'hA5, 1'b0, 1'b1);                  // no scan running, ignored
        send_record(1'b0, 1, 8'h7F, REC_GOOD);
        send_byte(8'h3C, 1'b1, 1'b1);                  // scan dropped by the next start
        send_byte(8'hC3, 1'b0, 1'b1);
        send_record(1'b1, 1, 8'h80, REC_GOOD);         // revision wraps, bank 1 newer
        send_byte(8'h00, 1'b0, 1'b0);                  // after trailer, ignored
        send_record(1'b1, 0, 8'h80, REC_GOOD);         // empty text
        write_size(17'd0);
        send_byte(8'hFF, 1'b1, 1'b1);                  // bad size on the first byte
    endtask

    task automatic test_size_sweep;
        int unsigned sizes [14];
        sizes = '{6, 7, 0, 40, 5, 131071, 12, 1, 65536, 64, 3, 20, 4096, 9};
        foreach (sizes[k]) begin
            write_size(17'(sizes[k]));
            random_traffic(70);
        end
    endtask

    task automatic test_largest_bank;
        sender_gaps = 1'b0;
        receiver_stalls = 1'b0;
        // 17-bit all ones is clamped to the largest bank
        write_size(17'h1FFFF);
        send_record(1'b0, 150, 8'h01, REC_GOOD);
        send_record(1'b1, 100, 8'h02, REC_GOOD);
        sender_gaps = 1'b1;
        receiver_stalls = 1'b1;
    endtask

    task automatic test_steady_stream;
        sender_gaps = 1'b0;
        receiver_stalls = 1'b0;
        write_size(17'($urandom_range(6, 48)));
        random_traffic(150);
    endtask

    always @(posedge aclk) begin : check_results
        bank_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_reports.size() == 0) begin
                report_mismatch("result with nothing pending", m_tdata[31:0], 32'h0);
            end else begin
                want = expected_reports.pop_front();
                if (m_tuser[0] !== want.bank)
                    report_mismatch("checked_bank", 32'(m_tuser[0]), 32'(want.bank));
                if (m_tdata[1:0] !== want.status)
                    report_mismatch("check_status", 32'(m_tdata[1:0]), 32'(want.status));
                if (m_tdata[17:2] !== want.text_len)
                    report_mismatch("text_length", 32'(m_tdata[17:2]), 32'(want.text_len));
                if (m_tdata[25:18] !== want.rev)
                    report_mismatch("revision", 32'(m_tdata[25:18]), 32'(want.rev));
                if (m_tdata[27:26] !== want.chosen)
                    report_mismatch("chosen_bank", 32'(m_tdata[27:26]), 32'(want.chosen));
                if (m_tdata[43:28] !== want.chosen_len)
                    report_mismatch("chosen_length", 32'(m_tdata[43:28]),
                                    32'(want.chosen_len));
                if (m_tdata[47:44] !== 4'h0)
                    report_mismatch("pad bits", 32'(m_tdata[47:44]), 32'h0);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (receiver_stalls && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin
        aresetn <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        mismatches = 0;
        bytes_sent = 0;
        quiet_cycles = 0;
        sender_gaps = 1'b1;
        receiver_stalls = 1'b1;
        scan_ph = frcs_pkg::PH_IDLE;
        scan_crc = '0;
        scan_pos = 0;
        text_seen = 0;
        rev_seen = '0;
        bank_ok = '{1'b0, 1'b0};
        bank_len = '{0, 0};
        bank_rev = '{8'h0, 8'h0};
        size_limit = 4096;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_size_sweep();
        test_largest_bank();
        test_steady_stream();

        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
`default_nettype wire
